[hw/rtl/idxp_pkg.sv]
// shared types and constants for the idx stream parser
`timescale 1ns / 1ps

package idxp_pkg;

    localparam int DEF_QUEUE_DEPTH = 2;

    // result kinds
    localparam logic [1:0] KIND_ELEMENT   = 2'd0;
    localparam logic [1:0] KIND_HEADER    = 2'd1;
    localparam logic [1:0] KIND_BAD_MAGIC = 2'd2;
    localparam logic [1:0] KIND_BAD_TYPE  = 2'd3;

    // element type codes as reported on results
    localparam logic [2:0] ETYPE_UINT8   = 3'd0;
    localparam logic [2:0] ETYPE_INT8    = 3'd1;
    localparam logic [2:0] ETYPE_INT16   = 3'd2;
    localparam logic [2:0] ETYPE_INT32   = 3'd3;
    localparam logic [2:0] ETYPE_FLOAT32 = 3'd4;
    localparam logic [2:0] ETYPE_DOUBLE  = 3'd5;
    localparam logic [2:0] ETYPE_UNKNOWN = 3'd6;

    // one result on its way from the parser to the output stage
    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] bits;
        logic [2:0]  etype;
        logic        matrix;
        logic [31:0] items;
        logic [31:0] rows;
        logic [31:0] cols;
        logic        last;
    } idxp_token_t;

endpackage

[hw/rtl/idxp_ifs.sv]
// valid/ready channel interfaces for file bytes and parse results
`timescale 1ns / 1ps

interface idxp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] file_byte;
    logic       first_byte;

    modport source (output valid, file_byte, first_byte, input ready);
    modport sink (input valid, file_byte, first_byte, output ready);
endinterface

interface idxp_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [63:0] element_bits;
    logic [2:0]  element_type;
    logic        is_matrix;
    logic [31:0] item_total;
    logic [31:0] row_total;
    logic [31:0] col_total;
    logic        final_result;

    modport source (output valid, result_kind, element_bits, element_type, is_matrix,
                    item_total, row_total, col_total, final_result, input ready);
    modport sink (input valid, result_kind, element_bits, element_type, is_matrix,
                  item_total, row_total, col_total, final_result, output ready);
endinterface

[hw/rtl/idxp_front.sv]
// byte-level parser: header decode, element assembly and element counting
`timescale 1ns / 1ps

module idxp_front (
    input  logic               clk,
    input  logic               rst_n,
    idxp_byte_if.sink          bytes,
    input  logic               queue_space,
    output logic               tok_valid,
    output idxp_pkg::idxp_token_t tok
);
    import idxp_pkg::*;

    typedef enum logic [2:0] {
        PH_MAGIC,
        PH_COUNT,
        PH_ROWS,
        PH_COLS,
        PH_DATA,
        PH_DONE
    } phase_t;

    phase_t      phase_reg, phase_next, cur_phase;
    logic [2:0]  idx_reg, idx_next, cur_idx;
    logic [63:0] shift_reg, shift_next, cur_shift;
    logic [2:0]  type_reg, type_next, cur_type;
    logic        matrix_reg, matrix_next, cur_matrix;
    logic [31:0] items_reg, items_next, cur_items;
    logic [31:0] rows_reg, rows_next, cur_rows;
    logic [31:0] cols_reg, cols_next, cur_cols;
    logic [31:0] item_cnt_reg, item_cnt_next, cur_item_cnt;
    logic [31:0] row_cnt_reg, row_cnt_next, cur_row_cnt;
    logic [31:0] col_cnt_reg, col_cnt_next, cur_col_cnt;

    logic        accept;
    logic [63:0] shifted;
    logic [31:0] word;
    logic [3:0]  need;
    logic [31:0] item_inc, row_inc, col_inc;
    logic        last;
    logic        empty;

    function automatic logic [3:0] elem_bytes(input logic [2:0] t);
        logic [3:0] n;
        if (t <= ETYPE_INT8)
            n = 4'd1;
        else if (t == ETYPE_INT16)
            n = 4'd2;
        else if (t == ETYPE_INT32 || t == ETYPE_FLOAT32)
            n = 4'd4;
        else
            n = 4'd8;
        return n;
    endfunction

    function automatic logic [2:0] decode_type(input logic [7:0] code);
        logic [2:0] t;
        unique case (code)
            8'h08:   t = ETYPE_UINT8;
            8'h09:   t = ETYPE_INT8;
            8'h0B:   t = ETYPE_INT16;
            8'h0C:   t = ETYPE_INT32;
            8'h0D:   t = ETYPE_FLOAT32;
            8'h0E:   t = ETYPE_DOUBLE;
            default: t = ETYPE_UNKNOWN;
        endcase
        return t;
    endfunction

    assign accept      = bytes.valid && queue_space;
    assign bytes.ready = queue_space;

    // a first byte sees the state as just after reset
    always_comb
    begin
        if (bytes.first_byte)
        begin
            cur_phase    = PH_MAGIC;
            cur_idx      = '0;
            cur_shift    = '0;
            cur_type     = '0;
            cur_matrix   = 1'b0;
            cur_items    = '0;
            cur_rows     = '0;
            cur_cols     = '0;
            cur_item_cnt = '0;
            cur_row_cnt  = '0;
            cur_col_cnt  = '0;
        end
        else
        begin
            cur_phase    = phase_reg;
            cur_idx      = idx_reg;
            cur_shift    = shift_reg;
            cur_type     = type_reg;
            cur_matrix   = matrix_reg;
            cur_items    = items_reg;
            cur_rows     = rows_reg;
            cur_cols     = cols_reg;
            cur_item_cnt = item_cnt_reg;
            cur_row_cnt  = row_cnt_reg;
            cur_col_cnt  = col_cnt_reg;
        end
    end

    assign shifted  = {cur_shift[55:0], bytes.file_byte};
    assign word     = shifted[31:0];
    assign need     = (cur_phase == PH_DATA) ? elem_bytes(cur_type) : 4'd4;
    assign item_inc = cur_item_cnt + 32'd1;
    assign row_inc  = cur_row_cnt + 32'd1;
    assign col_inc  = cur_col_cnt + 32'd1;

    always_comb
    begin
        phase_next    = phase_reg;
        idx_next      = idx_reg;
        shift_next    = shift_reg;
        type_next     = type_reg;
        matrix_next   = matrix_reg;
        items_next    = items_reg;
        rows_next     = rows_reg;
        cols_next     = cols_reg;
        item_cnt_next = item_cnt_reg;
        row_cnt_next  = row_cnt_reg;
        col_cnt_next  = col_cnt_reg;
        tok_valid     = 1'b0;
        last          = 1'b0;
        empty         = 1'b0;
        tok.kind      = KIND_ELEMENT;
        tok.bits      = '0;
        tok.last      = 1'b0;

        if (accept)
        begin
            phase_next    = cur_phase;
            idx_next      = cur_idx;
            shift_next    = cur_shift;
            type_next     = cur_type;
            matrix_next   = cur_matrix;
            items_next    = cur_items;
            rows_next     = cur_rows;
            cols_next     = cur_cols;
            item_cnt_next = cur_item_cnt;
            row_cnt_next  = cur_row_cnt;
            col_cnt_next  = cur_col_cnt;

            if (cur_phase != PH_DONE)
            begin
                shift_next = shifted;
                if ({1'b0, cur_idx} + 4'd1 < need)
                begin
                    idx_next = cur_idx + 3'd1;
                end
                else
                begin
                    idx_next   = '0;
                    shift_next = '0;
                    unique case (cur_phase)
                        PH_MAGIC:
                        begin
                            if (word[31:16] != 16'h0000)
                            begin
                                type_next   = '0;
                                matrix_next = 1'b0;
                                phase_next  = PH_DONE;
                                tok_valid   = 1'b1;
                                tok.kind    = KIND_BAD_MAGIC;
                                tok.last    = 1'b1;
                            end
                            else
                            begin
                                type_next   = decode_type(word[15:8]);
                                matrix_next = (word[7:0] == 8'h03);
                                phase_next  = PH_COUNT;
                            end
                        end
                        PH_COUNT, PH_COLS:
                        begin
                            if (cur_phase == PH_COUNT)
                                items_next = word;
                            else
                                cols_next = word;
                            if (cur_phase == PH_COUNT && cur_matrix)
                            begin
                                phase_next = PH_ROWS;
                            end
                            else
                            begin
                                tok_valid = 1'b1;
                                if (cur_type == ETYPE_UNKNOWN)
                                begin
                                    tok.kind   = KIND_BAD_TYPE;
                                    tok.last   = 1'b1;
                                    phase_next = PH_DONE;
                                end
                                else
                                begin
                                    empty = (items_next == 32'd0) ||
                                            (cur_matrix && (rows_next == 32'd0 ||
                                                            cols_next == 32'd0));
                                    tok.kind   = KIND_HEADER;
                                    tok.last   = empty;
                                    phase_next = empty ? PH_DONE : PH_DATA;
                                end
                            end
                        end
                        PH_ROWS:
                        begin
                            rows_next  = word;
                            phase_next = PH_COLS;
                        end
                        PH_DATA:
                        begin
                            if (cur_matrix)
                            begin
                                last = (col_inc == cur_cols) && (row_inc == cur_rows) &&
                                       (item_inc == cur_items);
                                if (col_inc >= cur_cols)
                                begin
                                    col_cnt_next = '0;
                                    if (row_inc >= cur_rows)
                                    begin
                                        row_cnt_next  = '0;
                                        item_cnt_next = item_inc;
                                    end
                                    else
                                    begin
                                        row_cnt_next = row_inc;
                                    end
                                end
                                else
                                begin
                                    col_cnt_next = col_inc;
                                end
                            end
                            else
                            begin
                                last          = (item_inc == cur_items);
                                item_cnt_next = item_inc;
                            end
                            tok_valid = 1'b1;
                            tok.kind  = KIND_ELEMENT;
                            tok.bits  = shifted;
                            tok.last  = last;
                            if (last)
                                phase_next = PH_DONE;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
        end

        tok.etype  = type_next;
        tok.matrix = matrix_next;
        tok.items  = items_next;
        tok.rows   = rows_next;
        tok.cols   = cols_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_MAGIC;
            idx_reg      <= '0;
            shift_reg    <= '0;
            type_reg     <= '0;
            matrix_reg   <= 1'b0;
            items_reg    <= '0;
            rows_reg     <= '0;
            cols_reg     <= '0;
            item_cnt_reg <= '0;
            row_cnt_reg  <= '0;
            col_cnt_reg  <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            idx_reg      <= idx_next;
            shift_reg    <= shift_next;
            type_reg     <= type_next;
            matrix_reg   <= matrix_next;
            items_reg    <= items_next;
            rows_reg     <= rows_next;
            cols_reg     <= cols_next;
            item_cnt_reg <= item_cnt_next;
            row_cnt_reg  <= row_cnt_next;
            col_cnt_reg  <= col_cnt_next;
        end
    end

endmodule

[hw/rtl/idxp_queue.sv]
// short result queue between the parser and the output stage
`timescale 1ns / 1ps

module idxp_queue #(
    parameter int DEPTH = idxp_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  idxp_pkg::idxp_token_t push_tok,
    output logic                  space,
    output logic                  pop_valid,
    output idxp_pkg::idxp_token_t pop_tok,
    input  logic                  pop
);
    import idxp_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    idxp_token_t   slots [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign space     = (count_reg != CW'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_tok   = slots[rd_ptr_reg];
    assign do_push   = push && space;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots[wr_ptr_reg] <= push_tok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[hw/rtl/idxp_back.sv]
// output stage: formats queued results into the result register
`timescale 1ns / 1ps

module idxp_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  tok_valid,
    input  idxp_pkg::idxp_token_t tok,
    output logic                  tok_take,
    idxp_result_if.source         results
);
    import idxp_pkg::*;

    logic        valid_reg;
    logic [1:0]  kind_reg;
    logic [63:0] bits_reg;
    logic [2:0]  etype_reg;
    logic        matrix_reg;
    logic [31:0] items_reg;
    logic [31:0] rows_reg;
    logic [31:0] cols_reg;
    logic        last_reg;

    assign tok_take = tok_valid && (!valid_reg || results.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (tok_take)
            valid_reg <= 1'b1;
        else if (results.ready)
            valid_reg <= 1'b0;
    end

    // rows and columns only mean something for matrix files
    always_ff @(posedge clk)
    begin
        if (tok_take)
        begin
            kind_reg   <= tok.kind;
            bits_reg   <= (tok.kind == KIND_ELEMENT) ? tok.bits : 64'd0;
            etype_reg  <= tok.etype;
            matrix_reg <= tok.matrix;
            items_reg  <= tok.items;
            rows_reg   <= tok.matrix ? tok.rows : 32'd0;
            cols_reg   <= tok.matrix ? tok.cols : 32'd0;
            last_reg   <= tok.last;
        end
    end

    assign results.valid        = valid_reg;
    assign results.result_kind  = kind_reg;
    assign results.element_bits = bits_reg;
    assign results.element_type = etype_reg;
    assign results.is_matrix    = matrix_reg;
    assign results.item_total   = items_reg;
    assign results.row_total    = rows_reg;
    assign results.col_total    = cols_reg;
    assign results.final_result = last_reg;

endmodule

[hw/rtl/idx_stream_parser.sv]
// top level of the idx dataset stream parser
`timescale 1ns / 1ps

// Takes an IDX file one byte per transaction and parses the big-endian header
// (magic word, item count, rows and columns for matrices), then assembles data
// elements of 1, 2, 4 or 8 bytes and delivers them as raw bits. A byte with
// first_byte set starts a new file. One byte is taken every cycle while the
// queue has room; the parser updates its shift register and element counters
// on the clock edge that accepts each byte; a result goes into the queue when
// the byte completing it is accepted and then on into the output register. A
// queue of QUEUE_DEPTH results lies between the parser and output register,
// so the byte side keeps going until that queue is full while the result side
// is stalled. No clearing pass is needed after reset.

module idx_stream_parser #(
    parameter int QUEUE_DEPTH = idxp_pkg::DEF_QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    idxp_byte_if.sink     bytes,
    idxp_result_if.source results
);
    import idxp_pkg::*;

    logic        tok_valid;
    idxp_token_t tok;
    logic        queue_space;
    logic        q_valid;
    idxp_token_t q_tok;
    logic        q_take;

    idxp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .bytes       (bytes),
        .queue_space (queue_space),
        .tok_valid   (tok_valid),
        .tok         (tok)
    );

    idxp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (tok_valid),
        .push_tok  (tok),
        .space     (queue_space),
        .pop_valid (q_valid),
        .pop_tok   (q_tok),
        .pop       (q_take)
    );

    idxp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (q_valid),
        .tok       (q_tok),
        .tok_take  (q_take),
        .results   (results)
    );

    // error results always close the file
    a_error_final : assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && (results.result_kind == KIND_BAD_MAGIC ||
                          results.result_kind == KIND_BAD_TYPE)
        |-> results.final_result)
        else $error("error result without final mark");

    // only element results carry element bits
    a_bits_zero : assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.result_kind != KIND_ELEMENT
        |-> results.element_bits == 64'd0)
        else $error("non-element result carries element bits");

    // 1d files report no rows or columns
    a_vector_dims : assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && !results.is_matrix
        |-> results.row_total == 32'd0 && results.col_total == 32'd0)
        else $error("1d result reports rows or columns");

    // a parsed byte never finds the queue full
    a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid |-> queue_space)
        else $error("result produced with no queue space");

endmodule

[tb/tb_idx_stream_parser.sv]
// self-checking testbench for the idx stream parser with random handshake timing
`timescale 1ns / 1ps

module tb_idx_stream_parser;

    import idxp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_BYTES = 250;

    typedef enum logic [2:0] {
        AT_MAGIC,
        AT_COUNT,
        AT_ROWS,
        AT_COLS,
        AT_DATA,
        AT_DONE
    } parse_phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
    } stream_byte_t;

    logic clk;
    logic rst_n;

    idxp_byte_if   bif ();
    idxp_result_if rif ();

    idx_stream_parser dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (bif),
        .results (rif)
    );

    stream_byte_t file_bytes_q[$];
    idxp_token_t  results_due[$];

    // parser state as predicted from the accepted bytes
    parse_phase_t cur_phase  = AT_MAGIC;
    logic [2:0]   byte_pos   = '0;
    logic [63:0]  asm_word   = '0;
    logic [2:0]   cur_etype  = ETYPE_UINT8;
    logic         cur_matrix = 1'b0;
    logic [31:0]  hdr_items  = '0;
    logic [31:0]  hdr_rows   = '0;
    logic [31:0]  hdr_cols   = '0;
    logic [31:0]  item_cnt   = '0;
    logic [31:0]  row_cnt    = '0;
    logic [31:0]  col_cnt    = '0;

    int          mismatches = 0;
    int          results_seen;
    int          cycles = 0;
    int unsigned src_gap;
    int unsigned snk_wait;
    int unsigned hold_left;
    int unsigned next_hold_at;
    logic        src_steady = 1'b0;
    logic        snk_steady = 1'b0;

    function automatic void queue_result(logic [1:0] kind, logic [63:0] bits, logic fin);
        idxp_token_t t;
        t.kind   = kind;
        t.bits   = bits;
        t.etype  = cur_etype;
        t.matrix = cur_matrix;
        t.items  = hdr_items;
        t.rows   = cur_matrix ? hdr_rows : 32'd0;
        t.cols   = cur_matrix ? hdr_cols : 32'd0;
        t.last   = fin;
        results_due = {results_due, t};
    endfunction

    task automatic close_header();
        logic empty;
        if (cur_etype == ETYPE_UNKNOWN)
        begin
            queue_result(KIND_BAD_TYPE, '0, 1'b1);
            cur_phase = AT_DONE;
        end
        else
        begin
            empty = (hdr_items == 0) || (cur_matrix && (hdr_rows == 0 || hdr_cols == 0));
            queue_result(KIND_HEADER, '0, empty);
            cur_phase = empty ? AT_DONE : AT_DATA;
        end
    endtask

    task automatic parse_file_byte(input logic [7:0] b, input logic start);
        int          need;
        logic [31:0] w;
        logic        last;
        if (start)
        begin
            cur_phase  = AT_MAGIC;
            byte_pos   = '0;
            asm_word   = '0;
            cur_etype  = ETYPE_UINT8;
            cur_matrix = 1'b0;
            hdr_items  = '0;
            hdr_rows   = '0;
            hdr_cols   = '0;
            item_cnt   = '0;
            row_cnt    = '0;
            col_cnt    = '0;
        end
        if (cur_phase == AT_DONE)
            return;
        asm_word = {asm_word[55:0], b};
        if (cur_phase != AT_DATA)
            need = 4;
        else
        begin
            case (cur_etype)
                ETYPE_UINT8, ETYPE_INT8:    need = 1;
                ETYPE_INT16:                need = 2;
                ETYPE_INT32, ETYPE_FLOAT32: need = 4;
                default:                    need = 8;
            endcase
        end
        if (int'(byte_pos) + 1 < need)
        begin
            byte_pos = byte_pos + 3'd1;
            return;
        end
        byte_pos = '0;
        w = asm_word[31:0];
        case (cur_phase)
            AT_MAGIC:
            begin
                asm_word = '0;
                if (w[31:16] != 16'd0)
                begin
                    cur_etype  = ETYPE_UINT8;
                    cur_matrix = 1'b0;
                    queue_result(KIND_BAD_MAGIC, '0, 1'b1);
                    cur_phase = AT_DONE;
                end
                else
                begin
                    case (w[15:8])
                        8'h08:   cur_etype = ETYPE_UINT8;
                        8'h09:   cur_etype = ETYPE_INT8;
                        8'h0B:   cur_etype = ETYPE_INT16;
                        8'h0C:   cur_etype = ETYPE_INT32;
                        8'h0D:   cur_etype = ETYPE_FLOAT32;
                        8'h0E:   cur_etype = ETYPE_DOUBLE;
                        default: cur_etype = ETYPE_UNKNOWN;
                    endcase
                    cur_matrix = (w[7:0] == 8'd3);
                    cur_phase = AT_COUNT;
                end
            end
            AT_COUNT:
            begin
                asm_word = '0;
                hdr_items = w;
                if (cur_matrix)
                    cur_phase = AT_ROWS;
                else
                    close_header();
            end
            AT_ROWS:
            begin
                asm_word = '0;
                hdr_rows = w;
                cur_phase = AT_COLS;
            end
            AT_COLS:
            begin
                asm_word = '0;
                hdr_cols = w;
                close_header();
            end
            default:
            begin
                if (cur_matrix)
                begin
                    last = (col_cnt + 32'd1 == hdr_cols) && (row_cnt + 32'd1 == hdr_rows) &&
                           (item_cnt + 32'd1 == hdr_items);
                    col_cnt = col_cnt + 32'd1;
                    if (col_cnt >= hdr_cols)
                    begin
                        col_cnt = '0;
                        row_cnt = row_cnt + 32'd1;
                        if (row_cnt >= hdr_rows)
                        begin
                            row_cnt = '0;
                            item_cnt = item_cnt + 32'd1;
                        end
                    end
                end
                else
                begin
                    last = (item_cnt + 32'd1 == hdr_items);
                    item_cnt = item_cnt + 32'd1;
                end
                queue_result(KIND_ELEMENT, asm_word, last);
                asm_word = '0;
                if (last)
                    cur_phase = AT_DONE;
            end
        endcase
    endtask

    task automatic queue_byte(input logic [7:0] data, input logic start);
        stream_byte_t sb;
        sb.data  = data;
        sb.start = start;
        file_bytes_q = {file_bytes_q, sb};
    endtask

    task automatic queue_word(input logic [31:0] w, input logic start);
        queue_byte(w[31:24], start);
        queue_byte(w[23:16], 1'b0);
        queue_byte(w[15:8], 1'b0);
        queue_byte(w[7:0], 1'b0);
    endtask

    // header, then n_elems elements of random content sized by the type byte
    task automatic queue_idx_file(input logic [31:0] magic, input logic [31:0] items,
                                  input logic [31:0] rows, input logic [31:0] cols,
                                  input int n_elems, input logic start);
        int esize;
        queue_word(magic, start);
        queue_word(items, 1'b0);
        if (magic[7:0] == 8'd3)
        begin
            queue_word(rows, 1'b0);
            queue_word(cols, 1'b0);
        end
        case (magic[15:8])
            8'h08, 8'h09: esize = 1;
            8'h0B:        esize = 2;
            8'h0C, 8'h0D: esize = 4;
            default:      esize = 8;
        endcase
        repeat (n_elems * esize)
            queue_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic report_mismatch(input string msg);
        $display("result %0d: %s", results_seen, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // byte source: one transaction per queued byte, random gaps between them
    always @(posedge clk or negedge rst_n)
    begin : drive_bytes
        stream_byte_t nxt;
        if (!rst_n)
        begin
            bif.valid      <= 1'b0;
            bif.file_byte  <= '0;
            bif.first_byte <= 1'b0;
            src_gap        <= 0;
        end
        else
        begin
            if (bif.valid && bif.ready)
                parse_file_byte(bif.file_byte, bif.first_byte);
            if (!bif.valid || bif.ready)
            begin
                if (src_gap != 0)
                begin
                    bif.valid <= 1'b0;
                    src_gap   <= src_gap - 1;
                end
                else if (file_bytes_q.size() != 0)
                begin
                    nxt = file_bytes_q.pop_front();
                    bif.valid      <= 1'b1;
                    bif.file_byte  <= nxt.data;
                    bif.first_byte <= nxt.start;
                    if ($urandom_range(0, 31) == 0)
                        src_steady <= ~src_steady;
                    src_gap <= src_steady ? 0 : $urandom_range(0, 7);
                end
                else
                    bif.valid <= 1'b0;
            end
        end
    end

    // result sink: compares each transaction with the oldest predicted result
    always @(posedge clk or negedge rst_n)
    begin : watch_results
        int unsigned wait_next;
        idxp_token_t want;
        if (!rst_n)
        begin
            rif.ready    <= 1'b0;
            snk_wait     <= 0;
            results_seen <= 0;
        end
        else
        begin
            wait_next = snk_wait;
            if (rif.valid && rif.ready)
            begin
                results_seen <= results_seen + 1;
                if (results_due.size() == 0)
                    report_mismatch("result arrived with none predicted");
                else
                begin
                    want = results_due.pop_front();
                    check_field("result_kind", 64'(rif.result_kind), 64'(want.kind));
                    check_field("element_bits", rif.element_bits, want.bits);
                    check_field("element_type", 64'(rif.element_type), 64'(want.etype));
                    check_field("is_matrix", 64'(rif.is_matrix), 64'(want.matrix));
                    check_field("item_total", 64'(rif.item_total), 64'(want.items));
                    check_field("row_total", 64'(rif.row_total), 64'(want.rows));
                    check_field("col_total", 64'(rif.col_total), 64'(want.cols));
                    check_field("final_result", 64'(rif.final_result), 64'(want.last));
                end
                if ($urandom_range(0, 31) == 0)
                    snk_steady <= ~snk_steady;
                wait_next = snk_steady ? 0 : $urandom_range(0, 7);
            end
            else if (wait_next != 0)
                wait_next = wait_next - 1;
            snk_wait  <= wait_next;
            rif.ready <= (wait_next == 0) && (hold_left == 0);
        end
    end

    // long result stalls so the internal queue fills and the byte side backs up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left    <= 0;
            next_hold_at <= 30;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (next_hold_at != 0 && results_seen >= next_hold_at)
        begin
            hold_left    <= 250;
            next_hold_at <= (next_hold_at == 30) ? 120 : 0;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("idx_stream_parser: mismatch");
            $finish;
        end
    end

    initial
    begin : stimulus
        int          sel;
        int          n;
        int          full;
        int          stop_at;
        logic [7:0]  code;
        logic [7:0]  dim;
        logic [31:0] magic;
        logic [31:0] items;
        logic [31:0] rows;
        logic [31:0] cols;

        rst_n = 1'b0;

        // the first file follows reset directly, without a start flag
        queue_idx_file(32'h0000_0801, 32'd3, '0, '0, 3, 1'b0);
        // dimension byte other than 3 is taken as 1D
        queue_idx_file(32'h0000_0900, 32'd2, '0, '0, 2, 1'b1);
        queue_idx_file(32'h0000_0B03, 32'd1, 32'd2, 32'd2, 4, 1'b1);
        queue_idx_file(32'h0000_0C01, 32'd2, '0, '0, 2, 1'b1);
        queue_idx_file(32'h0000_0D03, 32'd1, 32'd1, 32'd1, 1, 1'b1);
        queue_idx_file(32'h0000_0EFF, 32'd2, '0, '0, 2, 1'b1);
        // bad magic, with trailing bytes that must be ignored
        queue_idx_file(32'h0001_0801, 32'd1, '0, '0, 2, 1'b1);
        queue_idx_file(32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, '0, 0, 1'b1);
        // unknown element types, 1D and matrix
        queue_idx_file(32'h0000_0701, 32'd2, '0, '0, 2, 1'b1);
        queue_idx_file(32'h0000_FF03, 32'd1, 32'd1, 32'd1, 1, 1'b1);
        // empty data sets
        queue_idx_file(32'h0000_0801, 32'd0, '0, '0, 2, 1'b1);
        queue_idx_file(32'h0000_0803, 32'd2, 32'd0, 32'd3, 1, 1'b1);
        queue_idx_file(32'h0000_0803, 32'd2, 32'd3, 32'd0, 1, 1'b1);
        // huge counts, cut short by the next file
        queue_idx_file(32'h0000_0803, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3, 1'b1);
        queue_idx_file(32'h0000_0C01, 32'hFFFF_FFFF, '0, '0, 2, 1'b1);
        // bytes after the final element
        queue_idx_file(32'h0000_0801, 32'd1, '0, '0, 3, 1'b1);
        // restart in the middle of the header and in the middle of an element
        queue_word(32'h0000_0C01, 1'b1);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_idx_file(32'h0000_0E01, 32'd2, '0, '0, 1, 1'b1);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hA5, 1'b0);

        stop_at = file_bytes_q.size() + RANDOM_BYTES;
        while (file_bytes_q.size() < stop_at)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 78)
            begin
                if (sel < 70)
                begin
                    case ($urandom_range(0, 5))
                        0:       code = 8'h08;
                        1:       code = 8'h09;
                        2:       code = 8'h0B;
                        3:       code = 8'h0C;
                        4:       code = 8'h0D;
                        default: code = 8'h0E;
                    endcase
                end
                else
                    code = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 7) == 0)
                    dim = 8'($urandom_range(0, 255));
                else
                    dim = $urandom_range(0, 1) ? 8'd3 : 8'd1;
                items = ($urandom_range(0, 15) == 0) ? 32'd0 : 32'($urandom_range(1, 3));
                rows  = ($urandom_range(0, 15) == 0) ? 32'd0 : 32'($urandom_range(1, 3));
                cols  = ($urandom_range(0, 15) == 0) ? 32'd0 : 32'($urandom_range(1, 3));
                full = (dim == 8'd3) ? int'(items * rows * cols) : int'(items);
                case ($urandom_range(0, 9))
                    0:       n = (full > 0) ? $urandom_range(0, full - 1) : 0;
                    1:       n = full + $urandom_range(1, 3);
                    default: n = full;
                endcase
                queue_idx_file({16'h0000, code, dim}, items, rows, cols, n, 1'b1);
            end
            else if (sel < 86)
            begin
                magic = $urandom;
                if (magic[31:16] == 16'd0)
                    magic[31] = 1'b1;
                queue_idx_file(magic, $urandom, $urandom, $urandom,
                               $urandom_range(0, 2), 1'b1);
            end
            else if (sel < 92)
            begin
                magic = {16'h0000, 8'h08 + 8'($urandom_range(0, 6)),
                         $urandom_range(0, 1) ? 8'd3 : 8'd1};
                queue_idx_file(magic, $urandom, $urandom, $urandom,
                               $urandom_range(0, 4), 1'b1);
            end
            else
            begin
                repeat ($urandom_range(1, 12))
                    queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (file_bytes_q.size() != 0 || bif.valid)
            @(posedge clk);
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatches == 0)
            $display("idx_stream_parser: match");
        else
            $display("idx_stream_parser: mismatch");
        $finish;
    end

endmodule
